@@ hw/rtl/ntcp_pkg.sv @@
// ============================================================================
// ntcp_pkg: shared types and constants of the nested TLV chunk parser
// Holds the configuration record, the result record and parser constants.
// ============================================================================
package ntcp_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_IDX_TARGET_ID = 2'd0;
  localparam logic [1:0] CFG_IDX_ITEM_IDX  = 2'd1;
  localparam logic [1:0] CFG_IDX_MAX_BYTES = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [31:0] ID_ACCT             = 32'h4143_4354;
  localparam logic [7:0]  ITEM_INDEX_DEFAULT  = 8'd1;
  localparam logic [4:0]  BLOCK_LIMIT         = 5'd16;

  // Parser constants.
  localparam logic [2:0] HDR_LAST_BYTE = 3'd7;   // count value of the 8th header byte
  localparam logic [2:0] LEN_LAST_BYTE = 3'd3;   // count value of the 4th length byte
  localparam logic [2:0] LEN_DONE      = 3'd4;   // length complete, inside item data
  localparam logic [7:0] ITEM_CNT_MAX  = 8'd255;

  typedef enum logic {
    EVT_HEADER = 1'b0,
    EVT_ITEM   = 1'b1
  } event_kind_t;

  typedef struct packed {
    logic [31:0] target_chunk_id;
    logic [7:0]  name_item_index;
    logic [4:0]  max_name_bytes;
  } cfg_t;

  typedef struct packed {
    event_kind_t event_kind;
    logic [31:0] chunk_ident;
    logic [31:0] chunk_length;
    logic [7:0]  item_byte;
    logic        item_last;
  } result_t;

endpackage

@@ hw/rtl/ntcp_if.sv @@
// ============================================================================
// ntcp_if: stream channels of the nested TLV chunk parser
// Byte input channel and result channel, each with valid/ready handshake.
// ============================================================================
interface ntcp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_start;

  modport source (output valid, output data_byte, output stream_start, input ready);
  modport sink   (input valid, input data_byte, input stream_start, output ready);
endinterface

interface ntcp_out_if;
  logic        valid;
  logic        ready;
  logic        event_kind;
  logic [31:0] chunk_ident;
  logic [31:0] chunk_length;
  logic [7:0]  item_byte;
  logic        item_last;

  modport source (output valid, output event_kind, output chunk_ident, output chunk_length,
                  output item_byte, output item_last, input ready);
  modport sink   (input valid, input event_kind, input chunk_ident, input chunk_length,
                  input item_byte, input item_last, output ready);
endinterface

@@ hw/rtl/nested_tlv_chunk_parser.sv @@
// ============================================================================
// nested_tlv_chunk_parser: big-endian chunk and item stream parser
// Reports chunk headers and forwards the leading bytes of one selected item
// inside chunks whose id matches the target.
// ============================================================================
// Usage: one stream byte enters per beat on in_ch; stream_start set on a beat
// clears the parse state before that byte is taken. Each accepted byte yields
// zero or one result beat on out_ch: a header event when the eighth header
// byte completes, or an item event for each forwarded byte of the selected
// item, with item_last marking the final one.
// A result is computed combinationally from an accepted byte and registered
// into the result buffer that presents it on out_ch. One byte is taken per
// cycle while the buffer has a free entry; the parse state is counters and
// shift registers updated per accepted byte, then a two-entry result buffer.
// When the receiver stalls, the buffer absorbs up to two results; in_ch.ready
// drops only while both entries are occupied, and no result is dropped.
// Reset (rst_n low, synchronous) empties the buffer, clears the parse state
// so the next byte is taken as a header byte, and loads the configuration
// registers with their defaults (target id ACCT, item 1, 16 bytes).
// Configuration is written through cfg_we/cfg_index/cfg_wdata and should only
// change while no results are outstanding.
// ============================================================================
module nested_tlv_chunk_parser (
  input  logic        clk,
  input  logic        rst_n,
  ntcp_in_if.sink     in_ch,
  ntcp_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  ntcp_pkg::cfg_t    cfg;
  ntcp_pkg::result_t res;
  ntcp_pkg::result_t out_data;
  logic              res_valid;
  logic              buf_not_full;
  logic              accept;

  // A byte is taken whenever the result buffer has a free entry.
  assign in_ch.ready = buf_not_full;
  assign accept      = in_ch.valid && buf_not_full;

  ntcp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  ntcp_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .data_byte    (in_ch.data_byte),
    .stream_start (in_ch.stream_start),
    .cfg          (cfg),
    .res_valid    (res_valid),
    .res          (res)
  );

  // Results are pushed only for accepted bytes that produce one.
  ntcp_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept && res_valid),
    .push_data (res),
    .not_full  (buf_not_full),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

  assign out_ch.event_kind   = out_data.event_kind;
  assign out_ch.chunk_ident  = out_data.chunk_ident;
  assign out_ch.chunk_length = out_data.chunk_length;
  assign out_ch.item_byte    = out_data.item_byte;
  assign out_ch.item_last    = out_data.item_last;

endmodule

@@ hw/rtl/ntcp_cfg_regs.sv @@
// ============================================================================
// ntcp_cfg_regs: configuration registers
// Write-only register file for target id, selected item and byte limit.
// ============================================================================
module ntcp_cfg_regs (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [31:0]    cfg_wdata,
  output ntcp_pkg::cfg_t cfg_o
);

  ntcp_pkg::cfg_t cfg_r;
  ntcp_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        ntcp_pkg::CFG_IDX_TARGET_ID: cfg_nxt.target_chunk_id = cfg_wdata;
        ntcp_pkg::CFG_IDX_ITEM_IDX:  cfg_nxt.name_item_index = cfg_wdata[7:0];
        ntcp_pkg::CFG_IDX_MAX_BYTES: cfg_nxt.max_name_bytes  = cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_chunk_id <= ntcp_pkg::ID_ACCT;
      cfg_r.name_item_index <= ntcp_pkg::ITEM_INDEX_DEFAULT;
      cfg_r.max_name_bytes  <= ntcp_pkg::BLOCK_LIMIT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

@@ hw/rtl/ntcp_parser.sv @@
// ============================================================================
// ntcp_parser: chunk and item parse state
// Updates the header, length and item state for each accepted byte and
// produces at most one result in the same cycle.
// ============================================================================
module ntcp_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic              stream_start,
  input  ntcp_pkg::cfg_t    cfg,
  output logic              res_valid,
  output ntcp_pkg::result_t res
);

  logic [63:0] hs_r, hs_nxt, hs_w;
  logic [2:0]  hc_r, hc_nxt, hc_w;
  logic [31:0] pr_r, pr_nxt, pr_w;
  logic        inp_r, inp_nxt, inp_w;
  logic [31:0] ls_r, ls_nxt, ls_w;
  logic [2:0]  lc_r, lc_nxt, lc_w;
  logic [31:0] ir_r, ir_nxt, ir_w;
  logic [7:0]  ic_r, ic_nxt, ic_w;
  logic [4:0]  fc_r, fc_nxt, fc_w;

  logic [63:0] hs_sh;
  logic [31:0] ls_sh;
  logic [31:0] pr_dec;
  logic [31:0] ir_dec;
  logic [7:0]  ic_inc;
  logic [4:0]  limit;
  logic [4:0]  fc_inc;

  // A stream start clears all parse state ahead of the current byte.
  always_comb begin
    if (stream_start) begin
      hs_w = '0; hc_w = '0; pr_w = '0; inp_w = 1'b0;
      ls_w = '0; lc_w = '0; ir_w = '0; ic_w = '0; fc_w = '0;
    end else begin
      hs_w = hs_r; hc_w = hc_r; pr_w = pr_r; inp_w = inp_r;
      ls_w = ls_r; lc_w = lc_r; ir_w = ir_r; ic_w = ic_r; fc_w = fc_r;
    end
  end

  assign hs_sh  = {hs_w[55:0], data_byte};
  assign ls_sh  = {ls_w[23:0], data_byte};
  assign pr_dec = pr_w - 32'd1;
  assign ir_dec = (ir_w != 32'd0) ? (ir_w - 32'd1) : 32'd0;
  assign ic_inc = (ic_w == ntcp_pkg::ITEM_CNT_MAX) ? ic_w : (ic_w + 8'd1);
  assign limit  = (cfg.max_name_bytes > ntcp_pkg::BLOCK_LIMIT) ? ntcp_pkg::BLOCK_LIMIT
                                                               : cfg.max_name_bytes;
  assign fc_inc = fc_w + 5'd1;

  always_comb begin
    hs_nxt = hs_w; hc_nxt = hc_w; pr_nxt = pr_w; inp_nxt = inp_w;
    ls_nxt = ls_w; lc_nxt = lc_w; ir_nxt = ir_w; ic_nxt = ic_w; fc_nxt = fc_w;
    res_valid        = 1'b0;
    res.event_kind   = ntcp_pkg::EVT_HEADER;
    res.chunk_ident  = hs_w[63:32];
    res.chunk_length = hs_w[31:0];
    res.item_byte    = '0;
    res.item_last    = 1'b0;

    if (!inp_w) begin
      hs_nxt = hs_sh;
      if (hc_w == ntcp_pkg::HDR_LAST_BYTE) begin
        hc_nxt  = '0;
        pr_nxt  = hs_sh[31:0];
        inp_nxt = (hs_sh[31:0] != 32'd0);
        ls_nxt = '0; lc_nxt = '0; ir_nxt = '0; ic_nxt = '0; fc_nxt = '0;
        res_valid        = 1'b1;
        res.chunk_ident  = hs_sh[63:32];
        res.chunk_length = hs_sh[31:0];
      end else begin
        hc_nxt = hc_w + 3'd1;
      end
    end else begin
      pr_nxt = pr_dec;
      if (hs_w[63:32] == cfg.target_chunk_id) begin
        if (lc_w != ntcp_pkg::LEN_DONE) begin
          ls_nxt = ls_sh;
          lc_nxt = lc_w + 3'd1;
          if (lc_w == ntcp_pkg::LEN_LAST_BYTE) begin
            ir_nxt = ls_sh;
            fc_nxt = '0;
            if (ls_sh == 32'd0) begin
              // Empty item ends at once.
              ls_nxt = '0; lc_nxt = '0; ir_nxt = '0; fc_nxt = '0; ic_nxt = ic_inc;
            end
          end
        end else begin
          ir_nxt = ir_dec;
          if ((ic_w == cfg.name_item_index) && (fc_w < limit)) begin
            fc_nxt         = fc_inc;
            res_valid      = 1'b1;
            res.event_kind = ntcp_pkg::EVT_ITEM;
            res.item_byte  = data_byte;
            res.item_last  = (fc_inc == limit) || (ir_dec == 32'd0) || (pr_dec == 32'd0);
          end
          if (ir_dec == 32'd0) begin
            ls_nxt = '0; lc_nxt = '0; ir_nxt = '0; fc_nxt = '0; ic_nxt = ic_inc;
          end
        end
      end
      // Chunk end drops any partial item.
      if (pr_dec == 32'd0) begin
        inp_nxt = 1'b0;
        ls_nxt = '0; lc_nxt = '0; ir_nxt = '0; ic_nxt = '0; fc_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hs_r <= '0; hc_r <= '0; pr_r <= '0; inp_r <= 1'b0;
      ls_r <= '0; lc_r <= '0; ir_r <= '0; ic_r <= '0; fc_r <= '0;
    end else if (accept) begin
      hs_r <= hs_nxt; hc_r <= hc_nxt; pr_r <= pr_nxt; inp_r <= inp_nxt;
      ls_r <= ls_nxt; lc_r <= lc_nxt; ir_r <= ir_nxt; ic_r <= ic_nxt; fc_r <= fc_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_hdr_idle_in_payload: assert property (@(posedge clk) disable iff (!rst_n)
    inp_r |-> (hc_r == 3'd0))
    else $error("header count nonzero inside a payload");

  a_len_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    lc_r <= ntcp_pkg::LEN_DONE)
    else $error("length count out of range");

  a_fwd_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    fc_r <= ntcp_pkg::BLOCK_LIMIT)
    else $error("forwarded count above block limit");

  a_items_idle_outside: assert property (@(posedge clk) disable iff (!rst_n)
    !inp_r |-> (lc_r == 3'd0 && ic_r == 8'd0 && fc_r == 5'd0))
    else $error("item state left over outside a payload");
`endif

endmodule

@@ hw/rtl/ntcp_out_buf.sv @@
// ============================================================================
// ntcp_out_buf: two-entry result buffer
// Output register plus skid slot, so results may be pushed while the
// receiver stalls without losing one.
// ============================================================================
module ntcp_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ntcp_pkg::result_t push_data,
  output logic              not_full,
  output logic              out_valid,
  input  logic              out_ready,
  output ntcp_pkg::result_t out_data
);

  logic [1:0]        cnt_r, cnt_nxt;
  ntcp_pkg::result_t head_r, head_nxt;
  ntcp_pkg::result_t skid_r, skid_nxt;
  logic              pop;

  assign pop       = (cnt_r != 2'd0) && out_ready;
  assign not_full  = (cnt_r != 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = head_r;

  always_comb begin
    cnt_nxt  = cnt_r;
    head_nxt = head_r;
    skid_nxt = skid_r;
    case (cnt_r)
      2'd0: begin
        if (push) begin
          head_nxt = push_data;
          cnt_nxt  = 2'd1;
        end
      end
      2'd1: begin
        if (push && pop) begin
          head_nxt = push_data;
        end else if (push) begin
          skid_nxt = push_data;
          cnt_nxt  = 2'd2;
        end else if (pop) begin
          cnt_nxt = 2'd0;
        end
      end
      2'd2: begin
        if (pop) begin
          head_nxt = skid_r;
          cnt_nxt  = 2'd1;
        end
      end
      default: cnt_nxt = 2'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

`ifndef NO_ASSERTIONS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> not_full)
    else $error("result pushed into a full buffer");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("buffer count out of range");

  a_fill_to_two: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd1 && push && !pop) |=> (cnt_r == 2'd2 && skid_r == $past(push_data)))
    else $error("skid slot not loaded on stall");
`endif

endmodule

@@ dv/tb_top.sv @@
// ============================================================================
// tb_top: self-checking testbench of the nested TLV chunk parser
// Feeds chunk/item byte streams through the input channel in random bursts,
// predicts every header and item-byte event with a behavioral parser model,
// and checks each result beat, field by field, against the oldest prediction
// while the receiver stalls on its own pattern.
// ============================================================================
module tb_top;

  // Run length guard.
  localparam int CYCLE_LIMIT  = 300000;
  // Cycles allowed after the last predicted event before a register write or
  // the end of the run, for bytes that produce no event.
  localparam int SETTLE_CYCLES = 6;
  // Length of the one long receiver hold-off.
  localparam int HOLD_CYCLES   = 400;
  // Byte budget of each random phase.
  localparam int PHASE_BYTES   = 180;

  // Shapes of a generated chunk relative to its body.
  localparam int SHAPE_EXACT = 0;  // payload size equals the body
  localparam int SHAPE_CUT   = 1;  // payload size cuts the body short
  localparam int SHAPE_PAD   = 2;  // payload size runs past the body

  // Receiver stall patterns.
  localparam int RX_OPEN     = 0;
  localparam int RX_COIN     = 1;
  localparam int RX_PERIODIC = 2;
  localparam int RX_SPARSE   = 3;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } stream_beat_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;

  ntcp_in_if  byte_ch ();
  ntcp_out_if event_ch ();

  nested_tlv_chunk_parser u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (byte_ch),
    .out_ch   (event_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Bytes waiting to be offered, and events the model says must come out.
  stream_beat_t          pending_stream[$];
  ntcp_pkg::result_t     predicted_events[$];
  logic [7:0]            chunk_body[$];
  int                    beats_queued;
  int                    mismatch_count;
  int                    cycle_count;

  // --------------------------------------------------------------------------
  // Parser model. It mirrors the block's parse state and its own copy of the
  // configuration registers, and is stepped once per accepted input beat.
  // --------------------------------------------------------------------------
  ntcp_pkg::cfg_t model_cfg;
  logic [63:0] hdr_shift;     // chunk id in the high half, size in the low half
  logic [3:0]  hdr_count;
  logic [31:0] body_left;     // payload bytes still to come in this chunk
  logic        in_body;
  logic [31:0] len_shift;
  logic [2:0]  len_count;     // LEN_DONE once the item length is complete
  logic [31:0] item_left;
  logic [7:0]  item_index;    // saturating index of the current item
  logic [4:0]  sent_count;    // bytes forwarded from the current item

  function automatic void clear_item_state();
    len_shift  = '0;
    len_count  = '0;
    item_left  = '0;
    item_index = '0;
    sent_count = '0;
  endfunction

  function automatic void clear_stream_state();
    hdr_shift = '0;
    hdr_count = '0;
    body_left = '0;
    in_body   = 1'b0;
    clear_item_state();
  endfunction

  // Ends the current item and moves on to the next index, which sticks at
  // the top value once it gets there.
  function automatic void close_item();
    len_count  = '0;
    len_shift  = '0;
    item_left  = '0;
    sent_count = '0;
    if (item_index < ntcp_pkg::ITEM_CNT_MAX) item_index = item_index + 8'd1;
  endfunction

  task automatic parse_stream_byte(input logic [7:0] b, input logic start,
                                   output bit hit, output ntcp_pkg::result_t ev);
    logic [4:0] cap;
    hit = 1'b0;
    ev  = '0;
    if (start) clear_stream_state();
    if (!in_body) begin
      // Header bytes shift in; the eighth one reports the header. A size of
      // zero means the next byte is already a header byte again.
      hdr_shift = {hdr_shift[55:0], b};
      hdr_count = hdr_count + 4'd1;
      if (hdr_count >= 4'd8) begin
        hdr_count = '0;
        body_left = hdr_shift[31:0];
        in_body   = (body_left != 32'd0);
        clear_item_state();
        hit             = 1'b1;
        ev.event_kind   = ntcp_pkg::EVT_HEADER;
        ev.chunk_ident  = hdr_shift[63:32];
        ev.chunk_length = hdr_shift[31:0];
      end
    end else begin
      body_left = body_left - 32'd1;
      if (hdr_shift[63:32] == model_cfg.target_chunk_id) begin
        if (len_count != ntcp_pkg::LEN_DONE) begin
          len_shift = {len_shift[23:0], b};
          len_count = len_count + 3'd1;
          if (len_count == ntcp_pkg::LEN_DONE) begin
            item_left  = len_shift;
            sent_count = '0;
            // A zero-length item closes as soon as its length is known.
            if (item_left == 32'd0) close_item();
          end
        end else begin
          // Limits above BLOCK_LIMIT are clamped to it.
          cap = (model_cfg.max_name_bytes > ntcp_pkg::BLOCK_LIMIT) ? ntcp_pkg::BLOCK_LIMIT
                                                                   : model_cfg.max_name_bytes;
          if (item_left != 32'd0) item_left = item_left - 32'd1;
          if (item_index == model_cfg.name_item_index && sent_count < cap) begin
            sent_count      = sent_count + 5'd1;
            hit             = 1'b1;
            ev.event_kind   = ntcp_pkg::EVT_ITEM;
            ev.chunk_ident  = hdr_shift[63:32];
            ev.chunk_length = hdr_shift[31:0];
            ev.item_byte    = b;
            // The last forwarded byte is the one that hits the limit, ends
            // the item, or ends the chunk.
            ev.item_last    = (sent_count == cap) || (item_left == 32'd0) ||
                              (body_left == 32'd0);
          end
          if (item_left == 32'd0) close_item();
        end
      end
      // At the chunk end a partial length is dropped and items start over.
      if (body_left == 32'd0) begin
        in_body = 1'b0;
        clear_item_state();
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers. They only append to the pending byte queue; the driver
  // below takes bytes from it at its own pace.
  // --------------------------------------------------------------------------
  task automatic queue_beat(input logic [7:0] data, input logic start);
    stream_beat_t beat;
    beat.data  = data;
    beat.start = start;
    pending_stream.insert(pending_stream.size(), beat);
    beats_queued++;
  endtask

  task automatic queue_word(input logic [31:0] w, input logic start);
    queue_beat(w[31:24], start);
    queue_beat(w[23:16], 1'b0);
    queue_beat(w[15:8], 1'b0);
    queue_beat(w[7:0], 1'b0);
  endtask

  function automatic void body_byte(input logic [7:0] b);
    chunk_body.insert(chunk_body.size(), b);
  endfunction

  function automatic void body_word(input logic [31:0] w);
    body_byte(w[31:24]);
    body_byte(w[23:16]);
    body_byte(w[15:8]);
    body_byte(w[7:0]);
  endfunction

  // Fills chunk_body with a run of items. An item longer than the data we
  // care to send ends the body, so its chunk cuts it off.
  task automatic build_item_body(input int nitems);
    logic [31:0] len;
    int          pick;
    int          k;
    int          j;
    int          data_n;
    chunk_body.delete();
    for (k = 0; k < nitems; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) len = 32'd0;
      else if (pick < 70) len = $urandom_range(1, 20);
      else if (pick < 90) len = $urandom_range(15, 40);
      else len = $urandom;
      body_word(len);
      data_n = (len > 32'd40) ? 40 : int'(len);
      for (j = 0; j < data_n; j++) body_byte(8'($urandom_range(0, 255)));
      if (len > 32'd40) break;
    end
  endtask

  // Sends a header and as much of chunk_body as the chosen payload size
  // covers, padding with random bytes when the size runs past the body.
  task automatic emit_chunk(input logic [31:0] id, input int shape, input logic lead);
    int size;
    int i;
    size = chunk_body.size();
    if (shape == SHAPE_CUT) size = $urandom_range(0, size);
    else if (shape == SHAPE_PAD) size = size + $urandom_range(1, 6);
    queue_word(id, lead);
    queue_word(size, 1'b0);
    for (i = 0; i < size; i++) begin
      queue_beat((i < chunk_body.size()) ? chunk_body[i] : 8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  // Random traffic: mostly well-formed chunks with random content, some of
  // them cut short or padded, mixed with foreign chunks, empty chunks,
  // headers cut off by a restart, and loose noise with random restarts.
  task automatic gen_random_traffic(input int budget);
    int          stop_at;
    int          kind;
    int          pick;
    int          shape;
    bit          resync;
    logic        lead;
    logic [31:0] other_id;
    int          n;
    int          i;
    stop_at = beats_queued + budget;
    resync  = $urandom_range(0, 1);
    while (beats_queued < stop_at) begin
      kind   = $urandom_range(0, 99);
      lead   = resync || ($urandom_range(0, 3) == 0);
      resync = 1'b0;
      other_id = $urandom;
      if ($urandom_range(0, 1) == 0)
        other_id = model_cfg.target_chunk_id ^ (32'd1 << $urandom_range(0, 31));
      if (other_id == model_cfg.target_chunk_id) other_id = ~other_id;
      if (kind < 60) begin
        pick  = $urandom_range(0, 9);
        shape = (pick < 7) ? SHAPE_EXACT : (pick < 9) ? SHAPE_CUT : SHAPE_PAD;
        build_item_body($urandom_range(1, 6));
        emit_chunk(model_cfg.target_chunk_id, shape, lead);
      end else if (kind < 75) begin
        chunk_body.delete();
        n = $urandom_range(0, 16);
        for (i = 0; i < n; i++) body_byte(8'($urandom_range(0, 255)));
        emit_chunk(other_id, SHAPE_EXACT, lead);
      end else if (kind < 85) begin
        chunk_body.delete();
        emit_chunk(($urandom_range(0, 1) != 0) ? model_cfg.target_chunk_id : other_id,
                   SHAPE_EXACT, lead);
      end else if (kind < 90) begin
        // A header that never completes; the next sequence restarts.
        queue_beat(8'($urandom_range(0, 255)), lead);
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++) queue_beat(8'($urandom_range(0, 255)), 1'b0);
        resync = 1'b1;
      end else begin
        n = $urandom_range(1, 7);
        for (i = 0; i < n; i++) begin
          queue_beat(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end
        resync = 1'b1;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Configuration. Writes happen only while nothing is in flight, and the
  // model copy is updated along with each write.
  // --------------------------------------------------------------------------
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
  endtask

  task automatic set_config(input logic [31:0] target, input logic [7:0] index,
                            input logic [4:0] limit);
    write_reg(ntcp_pkg::CFG_IDX_TARGET_ID, target);
    model_cfg.target_chunk_id = target;
    write_reg(ntcp_pkg::CFG_IDX_ITEM_IDX, {24'd0, index});
    model_cfg.name_item_index = index;
    write_reg(ntcp_pkg::CFG_IDX_MAX_BYTES, {27'd0, limit});
    model_cfg.max_name_bytes = limit;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every queued byte has been accepted and every predicted
  // event has come out, then lets the block settle.
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_stream.size() != 0 || byte_ch.valid || predicted_events.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Driver: offers queued bytes in bursts of random length with random gaps.
  // A new beat is only put up once the current one has been taken.
  // --------------------------------------------------------------------------
  stream_beat_t next_beat;
  int           burst_left;
  int           gap_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      byte_ch.valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else if (!byte_ch.valid || byte_ch.ready) begin
      if (gap_left != 0 || pending_stream.size() == 0) begin
        if (gap_left != 0) gap_left--;
        byte_ch.valid <= 1'b0;
      end else begin
        next_beat = pending_stream.pop_front();
        byte_ch.valid        <= 1'b1;
        byte_ch.data_byte    <= next_beat.data;
        byte_ch.stream_start <= next_beat.start;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          // Some bursts are long and some gaps are empty, so the block also
          // sees stretches of back-to-back beats.
          burst_left = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 200 : 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: switches between stall patterns at random. Once
  // requested, it also holds ready low for one long stretch so that the
  // result buffer fills and the block pushes back on its input.
  // --------------------------------------------------------------------------
  bit hold_req;
  bit hold_done;
  int hold_left;
  int rx_mode;
  int rx_left;
  int rx_period = 2;
  int rx_tick;

  always @(posedge clk) begin
    rx_tick++;
    if (hold_req && !hold_done && hold_left == 0) hold_left = HOLD_CYCLES;
    if (hold_left != 0) begin
      hold_left--;
      if (hold_left == 0) hold_done = 1'b1;
      event_ch.ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode   = $urandom_range(RX_OPEN, RX_SPARSE);
        rx_left   = $urandom_range(16, 96);
        rx_period = $urandom_range(2, 5);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        RX_OPEN:     event_ch.ready <= 1'b1;
        RX_COIN:     event_ch.ready <= 1'($urandom_range(0, 1));
        RX_PERIODIC: event_ch.ready <= (rx_tick % rx_period) != 0;
        default:     event_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each result beat against the oldest prediction, then
  // steps the model with the input beat taken at the same edge. A result
  // always passes through the registered result buffer, so this order is safe.
  // --------------------------------------------------------------------------
  bit                new_hit;
  ntcp_pkg::result_t new_event;
  ntcp_pkg::result_t oldest_event;

  task automatic report_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
    mismatch_count++;
    $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      model_cfg.target_chunk_id = ntcp_pkg::ID_ACCT;
      model_cfg.name_item_index = ntcp_pkg::ITEM_INDEX_DEFAULT;
      model_cfg.max_name_bytes  = ntcp_pkg::BLOCK_LIMIT;
      clear_stream_state();
    end else begin
      if (event_ch.valid && event_ch.ready) begin
        if (predicted_events.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result beat, expected none, actual %h %h %h %h %h",
                   $time, event_ch.event_kind, event_ch.chunk_ident,
                   event_ch.chunk_length, event_ch.item_byte, event_ch.item_last);
        end else begin
          oldest_event = predicted_events.pop_front();
          if (event_ch.event_kind !== oldest_event.event_kind)
            report_field("event_kind", 32'(oldest_event.event_kind),
                         32'(event_ch.event_kind));
          if (event_ch.chunk_ident !== oldest_event.chunk_ident)
            report_field("chunk_ident", oldest_event.chunk_ident, event_ch.chunk_ident);
          if (event_ch.chunk_length !== oldest_event.chunk_length)
            report_field("chunk_length", oldest_event.chunk_length, event_ch.chunk_length);
          if (event_ch.item_byte !== oldest_event.item_byte)
            report_field("item_byte", 32'(oldest_event.item_byte), 32'(event_ch.item_byte));
          if (event_ch.item_last !== oldest_event.item_last)
            report_field("item_last", 32'(oldest_event.item_last), 32'(event_ch.item_last));
        end
      end
      if (byte_ch.valid && byte_ch.ready) begin
        parse_stream_byte(byte_ch.data_byte, byte_ch.stream_start, new_hit, new_event);
        if (new_hit) predicted_events.insert(predicted_events.size(), new_event);
      end
    end
  end

  // A hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  int i;

  initial begin
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = '0;
    cfg_wdata            = '0;
    byte_ch.valid        = 1'b0;
    byte_ch.data_byte    = '0;
    byte_ch.stream_start = 1'b0;
    event_ch.ready       = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: an empty target chunk, then a target chunk holding an empty
    // item 0 and a three-byte item 1 with extreme data values, then a header
    // that is cut off by the restart of the next sequence.
    set_config(ntcp_pkg::ID_ACCT, ntcp_pkg::ITEM_INDEX_DEFAULT, ntcp_pkg::BLOCK_LIMIT);
    chunk_body.delete();
    emit_chunk(ntcp_pkg::ID_ACCT, SHAPE_EXACT, 1'b1);
    body_word(32'd0);
    body_word(32'd3);
    body_byte(8'h00);
    body_byte(8'hFF);
    body_byte(8'h5A);
    emit_chunk(ntcp_pkg::ID_ACCT, SHAPE_EXACT, 1'b0);
    queue_beat(8'hFF, 1'b0);
    queue_beat(8'h00, 1'b0);
    queue_beat(8'h41, 1'b0);
    wait_idle();

    // The byte limit changes in the middle of the selected item: two bytes
    // go out under the full limit, then a limit of three ends it on the
    // next byte.
    chunk_body.delete();
    body_word(32'd0);
    body_word(32'd9);
    for (i = 0; i < 9; i++) body_byte(8'($urandom_range(0, 255)));
    queue_word(ntcp_pkg::ID_ACCT, 1'b1);
    queue_word(chunk_body.size(), 1'b0);
    for (i = 0; i < 10; i++) queue_beat(chunk_body[i], 1'b0);
    wait_idle();
    set_config(ntcp_pkg::ID_ACCT, ntcp_pkg::ITEM_INDEX_DEFAULT, 5'd3);
    for (i = 10; i < chunk_body.size(); i++) queue_beat(chunk_body[i], 1'b0);
    wait_idle();

    // Random phases over several register settings. The long receiver
    // hold-off starts with the first of them, while bytes keep coming.
    set_config(ntcp_pkg::ID_ACCT, ntcp_pkg::ITEM_INDEX_DEFAULT, ntcp_pkg::BLOCK_LIMIT);
    hold_req = 1'b1;
    gen_random_traffic(PHASE_BYTES);
    wait_idle();

    set_config(32'h0000_0000, 8'd0, 5'd1);
    gen_random_traffic(PHASE_BYTES);
    wait_idle();

    set_config(32'hFFFF_FFFF, 8'd2, 5'd31);
    gen_random_traffic(PHASE_BYTES);
    wait_idle();

    set_config($urandom, 8'($urandom_range(0, 5)), 5'd17);
    gen_random_traffic(PHASE_BYTES);
    wait_idle();

    set_config(ntcp_pkg::ID_ACCT, 8'($urandom_range(0, 3)), 5'($urandom_range(0, 16)));
    gen_random_traffic(PHASE_BYTES);
    wait_idle();

    if (mismatch_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
